// ----- rtl/spibd_pkg.sv -----
// ----------------------------------------------------------------------------
// spibd_pkg
// Shared types, constants and lookup functions for the SPI baud divider search.
// ----------------------------------------------------------------------------
package spibd_pkg;

    localparam int CLK_W  = 29;   // peripheral clock register
    localparam int REQ_W  = 32;   // requested rate / error
    localparam int RATE_W = 28;   // prescaled clock and candidate rates

    localparam logic [1:0] PRE_LAST    = 2'd3;
    localparam logic [1:0] PRE_THREE   = 2'd1;  // prescaler table entry with value 3
    localparam logic [3:0] SCL_DIV_IDX = 4'd2;  // scaler 6: not a power of two
    localparam logic [3:0] SCL_LAST    = 4'd15;

    localparam logic [CLK_W-1:0] PCLK_RESET = 29'd84000000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,       // latch request, clear best candidate
        OP_PRE_MUL,     // divider stage 1 on the doubled/base clock
        OP_PRE_LOAD,    // capture prescaled clock
        OP_S6_MUL,      // divider stage 1 on prescaled clock / 2, by three
        OP_S6_LOAD,     // capture divide-by-six candidate
        OP_EVAL_SHIFT,  // evaluate a power-of-two scaler candidate
        OP_EVAL_CAND,   // evaluate the captured candidate
        OP_OUT_LOAD     // move best candidate to the output register
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       dbl;
        logic [1:0] psel;
        logic [3:0] ssel;
    } t_cmd;

    // floor(2^32 / d) for d in {2, 3, 5, 7}
    function automatic logic [31:0] pre_recip(input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            2'd0:    r = 32'h8000_0000;
            2'd1:    r = 32'h5555_5555;
            2'd2:    r = 32'h3333_3333;
            2'd3:    r = 32'h2492_4924;
            default: r = 32'h8000_0000;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] pre_value(input logic [1:0] sel);
        logic [2:0] r;
        case (sel)
            2'd0:    r = 3'd2;
            2'd1:    r = 3'd3;
            2'd2:    r = 3'd5;
            2'd3:    r = 3'd7;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    // Right shift for scalers 2,4,(6),8,16..32768; index 2 goes through the divider
    function automatic logic [3:0] scl_shift(input logic [3:0] ssel);
        logic [3:0] r;
        case (ssel)
            4'd0:    r = 4'd1;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd1;
            4'd3:    r = 4'd3;
            default: r = ssel;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/spi_baud_divider_search.sv -----
// ----------------------------------------------------------------------------
// spi_baud_divider_search
// Finds the SPI doubler/prescaler/scaler setting closest to a requested rate.
// ----------------------------------------------------------------------------
// A search visits all 128 settings in order (doubler, prescaler, scaler) and
// keeps the first one with the smallest absolute rate error. Each prescaler
// pass runs the prescale divide, one evaluation per power-of-two scaler and
// the divide-by-six scaler, all through one shared constant divider and one
// compare per cycle. New requests are held off while a search runs. A result
// is loaded into an output register, and a new request can be taken in the
// cycle after, even while that result is still stalled. The clock register
// resets to 84 MHz.
// ----------------------------------------------------------------------------
module spi_baud_divider_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [28:0]                  i_cfg_peripheral_clock_hz,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [31:0]                  i_requested_rate_hz,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_double_rate,
    output logic [1:0]                   o_prescaler_select,
    output logic [3:0]                   o_scaler_select,
    output logic [27:0]                  o_achieved_rate_hz,
    output logic [31:0]                  o_rate_error_hz,
    output logic                         o_not_found
);

    spibd_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    spibd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    spibd_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_pclk         (i_cfg_peripheral_clock_hz),
        .i_req              (i_requested_rate_hz),
        .i_cmd              (w_cmd),
        .o_double_rate      (o_double_rate),
        .o_prescaler_select (o_prescaler_select),
        .o_scaler_select    (o_scaler_select),
        .o_achieved_rate_hz (o_achieved_rate_hz),
        .o_rate_error_hz    (o_rate_error_hz),
        .o_not_found        (o_not_found)
    );

endmodule

// ----- rtl/spibd_cdiv.sv -----
// ----------------------------------------------------------------------------
// spibd_cdiv
// Divider by a small constant (2, 3, 5 or 7): registered reciprocal multiply,
// then one remainder check and increment.
// ----------------------------------------------------------------------------
module spibd_cdiv (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [spibd_pkg::CLK_W-1:0]    i_num,
    input  logic [1:0]                     i_sel,
    output logic [spibd_pkg::RATE_W-1:0]   o_quot
);

    logic [spibd_pkg::CLK_W-1:0]    r_num;
    logic [1:0]                     r_sel;
    logic [spibd_pkg::CLK_W-1:0]    r_qest;

    logic [60:0]                    w_prod;
    logic [spibd_pkg::CLK_W-1:0]    w_back;
    logic [3:0]                     w_rem;
    logic                           w_fix;
    logic [spibd_pkg::CLK_W-1:0]    w_quot;

    assign w_prod = 61'(i_num) * 61'(spibd_pkg::pre_recip(i_sel));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num  <= i_num;
            r_sel  <= i_sel;
            r_qest <= w_prod[60:32];
        end
    end

    // estimate is exact or one low; remainder stays below 2*d
    assign w_back = r_qest * 29'(spibd_pkg::pre_value(r_sel));
    assign w_rem  = 4'(r_num - w_back);
    assign w_fix  = (w_rem >= 4'(spibd_pkg::pre_value(r_sel)));
    assign w_quot = r_qest + 29'(w_fix);
    assign o_quot = w_quot[spibd_pkg::RATE_W-1:0];

endmodule

// ----- rtl/spibd_dpath.sv -----
// ----------------------------------------------------------------------------
// spibd_dpath
// Datapath: clock register, prescaler, candidate rate, error compare,
// best-candidate and output registers.
// ----------------------------------------------------------------------------
module spibd_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spibd_pkg::CLK_W-1:0]    i_cfg_pclk,
    input  logic [spibd_pkg::REQ_W-1:0]    i_req,
    input  spibd_pkg::t_cmd                i_cmd,
    output logic                           o_double_rate,
    output logic [1:0]                     o_prescaler_select,
    output logic [3:0]                     o_scaler_select,
    output logic [spibd_pkg::RATE_W-1:0]   o_achieved_rate_hz,
    output logic [spibd_pkg::REQ_W-1:0]    o_rate_error_hz,
    output logic                           o_not_found
);

    logic [spibd_pkg::CLK_W-1:0]    r_pclk;
    logic [spibd_pkg::REQ_W-1:0]    r_req;
    logic [spibd_pkg::RATE_W-1:0]   r_pre;
    logic [spibd_pkg::RATE_W-1:0]   r_cand;
    logic [spibd_pkg::REQ_W-1:0]    r_best_err;
    logic [spibd_pkg::RATE_W-1:0]   r_best_rate;
    logic                           r_best_dbl;
    logic [1:0]                     r_best_psel;
    logic [3:0]                     r_best_ssel;

    logic                           r_out_dbl;
    logic [1:0]                     r_out_psel;
    logic [3:0]                     r_out_ssel;
    logic [spibd_pkg::RATE_W-1:0]   r_out_rate;
    logic [spibd_pkg::REQ_W-1:0]    r_out_err;
    logic                           r_out_nf;

    logic [spibd_pkg::CLK_W-2:0]    w_base;
    logic [spibd_pkg::CLK_W-1:0]    w_clkd;
    logic                           w_div_load;
    logic [spibd_pkg::CLK_W-1:0]    w_div_num;
    logic [1:0]                     w_div_sel;
    logic [spibd_pkg::RATE_W-1:0]   w_quot;
    logic [spibd_pkg::RATE_W-1:0]   w_rate;
    logic [spibd_pkg::REQ_W-1:0]    w_rate_ext;
    logic [spibd_pkg::REQ_W-1:0]    w_err;
    logic                           w_eval;
    logic                           w_better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pclk <= spibd_pkg::PCLK_RESET;
        end else if (i_cfg_we) begin
            r_pclk <= i_cfg_pclk;
        end
    end

    assign w_base = r_pclk[spibd_pkg::CLK_W-1:1];
    assign w_clkd = i_cmd.dbl ? {w_base, 1'b0} : {1'b0, w_base};

    assign w_div_load = (i_cmd.op == spibd_pkg::OP_PRE_MUL) ||
                        (i_cmd.op == spibd_pkg::OP_S6_MUL);
    // scaler 6: floor(floor(pre / 2) / 3)
    assign w_div_num  = (i_cmd.op == spibd_pkg::OP_S6_MUL) ?
                        {2'b00, r_pre[spibd_pkg::RATE_W-1:1]} : w_clkd;
    assign w_div_sel  = (i_cmd.op == spibd_pkg::OP_S6_MUL) ?
                        spibd_pkg::PRE_THREE : i_cmd.psel;

    spibd_cdiv u_cdiv (
        .i_clk  (i_clk),
        .i_load (w_div_load),
        .i_num  (w_div_num),
        .i_sel  (w_div_sel),
        .o_quot (w_quot)
    );

    assign w_rate     = (i_cmd.op == spibd_pkg::OP_EVAL_CAND) ? r_cand :
                        (r_pre >> spibd_pkg::scl_shift(i_cmd.ssel));
    assign w_rate_ext = 32'(w_rate);
    assign w_err      = (r_req >= w_rate_ext) ? (r_req - w_rate_ext) : (w_rate_ext - r_req);
    assign w_eval     = (i_cmd.op == spibd_pkg::OP_EVAL_SHIFT) ||
                        (i_cmd.op == spibd_pkg::OP_EVAL_CAND);
    assign w_better   = (w_err < r_best_err);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            spibd_pkg::OP_START: begin
                r_req       <= i_req;
                r_best_err  <= '1;
                r_best_rate <= '0;
                r_best_dbl  <= 1'b0;
                r_best_psel <= '0;
                r_best_ssel <= '0;
            end
            spibd_pkg::OP_PRE_LOAD: begin
                r_pre <= w_quot;
            end
            spibd_pkg::OP_S6_LOAD: begin
                r_cand <= w_quot;
            end
            spibd_pkg::OP_EVAL_SHIFT, spibd_pkg::OP_EVAL_CAND: begin
                if (w_better) begin
                    r_best_err  <= w_err;
                    r_best_rate <= w_rate;
                    r_best_dbl  <= i_cmd.dbl;
                    r_best_psel <= i_cmd.psel;
                    r_best_ssel <= i_cmd.ssel;
                end
            end
            spibd_pkg::OP_OUT_LOAD: begin
                r_out_dbl  <= r_best_dbl;
                r_out_psel <= r_best_psel;
                r_out_ssel <= r_best_ssel;
                r_out_rate <= r_best_rate;
                r_out_err  <= r_best_err;
                r_out_nf   <= (r_best_err == '1);
            end
            default: begin
            end
        endcase
    end

    assign o_double_rate      = r_out_dbl;
    assign o_prescaler_select = r_out_psel;
    assign o_scaler_select    = r_out_ssel;
    assign o_achieved_rate_hz = r_out_rate;
    assign o_rate_error_hz    = r_out_err;
    assign o_not_found        = r_out_nf;

    a_err_monotonic : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |=> (r_best_err <= $past(r_best_err)))
        else $error("best error grew during search");

    a_start_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == spibd_pkg::OP_START) |=> (r_best_err == '1))
        else $error("search did not start from all-ones error");

endmodule

// ----- rtl/spibd_ctrl.sv -----
// ----------------------------------------------------------------------------
// spibd_ctrl
// Sequencer: walks doubler, prescaler and scaler indexes, issues datapath
// commands and runs the input/output handshakes.
// ----------------------------------------------------------------------------
module spibd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output spibd_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_MUL,
        S_PRE_FIX,
        S_SCL,
        S_S6_FIX,
        S_S6_EVAL,
        S_DONE
    } t_state;

    t_state     r_state;
    logic       r_busy;
    logic       r_out_valid;
    logic       r_dbl;
    logic [1:0] r_psel;
    logic [3:0] r_ssel;

    logic       w_out_free;
    logic       w_out_xfer;

    assign w_out_xfer = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = spibd_pkg::OP_NONE;
        o_cmd.dbl  = r_dbl;
        o_cmd.psel = r_psel;
        o_cmd.ssel = r_ssel;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = spibd_pkg::OP_START;
                end
            end
            S_PRE_MUL: o_cmd.op = spibd_pkg::OP_PRE_MUL;
            S_PRE_FIX: o_cmd.op = spibd_pkg::OP_PRE_LOAD;
            S_SCL: begin
                if (r_ssel == spibd_pkg::SCL_DIV_IDX) begin
                    o_cmd.op = spibd_pkg::OP_S6_MUL;
                end else begin
                    o_cmd.op = spibd_pkg::OP_EVAL_SHIFT;
                end
            end
            S_S6_FIX:  o_cmd.op = spibd_pkg::OP_S6_LOAD;
            S_S6_EVAL: o_cmd.op = spibd_pkg::OP_EVAL_CAND;
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.op = spibd_pkg::OP_OUT_LOAD;
                end
            end
            default: o_cmd.op = spibd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_dbl       <= 1'b0;
            r_psel      <= '0;
            r_ssel      <= '0;
        end else begin
            // a new result may replace one that leaves in the same cycle
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_PRE_MUL;
                        r_busy  <= 1'b1;
                        r_dbl   <= 1'b0;
                        r_psel  <= '0;
                        r_ssel  <= '0;
                    end
                end
                S_PRE_MUL: r_state <= S_PRE_FIX;
                S_PRE_FIX: begin
                    r_state <= S_SCL;
                    r_ssel  <= '0;
                end
                S_SCL, S_S6_EVAL: begin
                    if (r_state == S_SCL && r_ssel == spibd_pkg::SCL_DIV_IDX) begin
                        r_state <= S_S6_FIX;
                    end else if (r_ssel != spibd_pkg::SCL_LAST) begin
                        r_state <= S_SCL;
                        r_ssel  <= r_ssel + 4'd1;
                    end else if (r_psel != spibd_pkg::PRE_LAST) begin
                        r_state <= S_PRE_MUL;
                        r_psel  <= r_psel + 2'd1;
                    end else if (!r_dbl) begin
                        r_state <= S_PRE_MUL;
                        r_dbl   <= 1'b1;
                        r_psel  <= '0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_S6_FIX: r_state <= S_S6_EVAL;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;

    a_busy_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with sequencer state");

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_PRE_MUL))
        else $error("accepted transfer did not start a search");

    a_scale6_divider : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCL && r_ssel == spibd_pkg::SCL_DIV_IDX) |=> (r_state == S_S6_FIX))
        else $error("scaler 6 skipped the divider");

    a_done_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a pending output transfer");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: SPI baud divider search testbench
// Sends requested bit rates under several peripheral clock settings and checks
// the selectors, achieved rate, error and not-found flag of every transfer.
// A directed table comes first, then random requests aimed at candidate rates
// and at midpoints between them, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 62;

    typedef struct {
        logic                          double_rate;
        logic [1:0]                    prescaler_select;
        logic [3:0]                    scaler_select;
        logic [spibd_pkg::RATE_W-1:0]  achieved_rate_hz;
        logic [spibd_pkg::REQ_W-1:0]   rate_error_hz;
        logic                          not_found;
    } t_divider_result;

    typedef enum logic {ROW_CLOCK, ROW_REQUEST} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [31:0]     value;
        bit              typed;
        t_divider_result want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [spibd_pkg::CLK_W-1:0]   i_cfg_peripheral_clock_hz;
    logic                          i_valid;
    logic                          o_stall;
    logic [spibd_pkg::REQ_W-1:0]   i_requested_rate_hz;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_double_rate;
    logic [1:0]                    o_prescaler_select;
    logic [3:0]                    o_scaler_select;
    logic [spibd_pkg::RATE_W-1:0]  o_achieved_rate_hz;
    logic [spibd_pkg::REQ_W-1:0]   o_rate_error_hz;
    logic                          o_not_found;

    t_divider_result               divider_due[$];
    t_stim_row                     directed_rows[$];
    t_divider_result               no_typed;
    logic [spibd_pkg::CLK_W-1:0]   pclk_model;
    bit                            quiet;
    int                            mismatch_count;
    int                            result_count;
    int                            not_found_count;
    int                            exact_count;
    int                            clock_writes;
    int                            cycle_count;

    spi_baud_divider_search u_top (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_peripheral_clock_hz (i_cfg_peripheral_clock_hz),
        .i_valid                   (i_valid),
        .o_stall                   (o_stall),
        .i_requested_rate_hz       (i_requested_rate_hz),
        .o_valid                   (o_valid),
        .i_stall                   (i_stall),
        .o_double_rate             (o_double_rate),
        .o_prescaler_select        (o_prescaler_select),
        .o_scaler_select           (o_scaler_select),
        .o_achieved_rate_hz        (o_achieved_rate_hz),
        .o_rate_error_hz           (o_rate_error_hz),
        .o_not_found               (o_not_found)
    );

    always #2 i_clk = ~i_clk;

    // Bit rate of one divider setting: floor(floor(clk / prescaler) / scaler)
    function automatic logic [31:0] cand_rate(input logic [spibd_pkg::CLK_W-1:0] pclk,
                                              input logic dbl,
                                              input logic [1:0] psel,
                                              input logic [3:0] ssel);
        logic [31:0] clk;
        logic [31:0] pdiv;
        logic [31:0] sdiv;
        clk = {4'd0, pclk[spibd_pkg::CLK_W-1:1]};
        if (dbl) begin
            clk = clk << 1;
        end
        case (psel)
            2'd0:    pdiv = 32'd2;
            2'd1:    pdiv = 32'd3;
            2'd2:    pdiv = 32'd5;
            default: pdiv = 32'd7;
        endcase
        case (ssel)
            4'd0:    sdiv = 32'd2;
            4'd1:    sdiv = 32'd4;
            4'd2:    sdiv = 32'd6;
            4'd3:    sdiv = 32'd8;
            default: sdiv = 32'd1 << ssel;
        endcase
        return (clk / pdiv) / sdiv;
    endfunction

    // Walk all 128 settings; a later one wins only on a strictly smaller error
    function automatic t_divider_result best_divider(
            input logic [spibd_pkg::CLK_W-1:0] pclk,
            input logic [31:0] req);
        t_divider_result best;
        logic [31:0]     rate;
        logic [31:0]     err;
        logic [31:0]     best_rate;
        best.double_rate      = 1'b0;
        best.prescaler_select = 2'd0;
        best.scaler_select    = 4'd0;
        best_rate             = 32'd0;
        best.rate_error_hz    = '1;
        for (int d = 0; d < 2; d++) begin
            for (int p = 0; p < 4; p++) begin
                for (int s = 0; s < 16; s++) begin
                    rate = cand_rate(pclk, d[0], p[1:0], s[3:0]);
                    err  = (req < rate) ? rate - req : req - rate;
                    if (err < best.rate_error_hz) begin
                        best.rate_error_hz    = err;
                        best_rate             = rate;
                        best.double_rate      = d[0];
                        best.prescaler_select = p[1:0];
                        best.scaler_select    = s[3:0];
                    end
                end
            end
        end
        best.achieved_rate_hz = best_rate[spibd_pkg::RATE_W-1:0];
        best.not_found        = (best.rate_error_hz == '1);
        return best;
    endfunction

    function automatic logic [spibd_pkg::CLK_W-1:0] pick_clock();
        logic [31:0] rnd;
        logic [31:0] pick;
        rnd = $urandom;
        case (rnd[1:0])
            2'd0: begin
                case (rnd[4:2])
                    3'd0:    pick = 32'd84000000;
                    3'd1:    pick = 32'd120000000;
                    3'd2:    pick = 32'd48000000;
                    3'd3:    pick = 32'd400000000;
                    3'd4:    pick = 32'd180000000;
                    default: pick = 32'd100000000;
                endcase
            end
            2'd1:    pick = $urandom_range(0, 400000000);
            2'd2:    pick = $urandom;
            default: pick = $urandom_range(0, 40);
        endcase
        return pick[spibd_pkg::CLK_W-1:0];
    endfunction

    // Mostly requests at or near reachable rates, and midpoints for ties
    function automatic logic [31:0] gen_request(input logic [spibd_pkg::CLK_W-1:0] pclk);
        logic [31:0] rnd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] req;
        rnd = $urandom;
        a   = cand_rate(pclk, rnd[8], rnd[10:9], rnd[14:11]);
        b   = cand_rate(pclk, rnd[15], rnd[17:16], rnd[21:18]);
        case ($urandom_range(0, 9))
            0:       req = $urandom;
            1: begin
                case (rnd[23:22])
                    2'd0:    req = 32'd0;
                    2'd1:    req = '1;
                    default: req = $urandom_range(0, 16);
                endcase
            end
            2, 3, 4, 5: req = a + $urandom_range(0, 6) - 32'd3;
            6, 7:    req = (a + b + {31'd0, rnd[24]}) >> 1;
            8:       req = $urandom % ({3'd0, pclk} + 32'd1);
            default: req = $urandom >> $urandom_range(0, 31);
        endcase
        return req;
    endfunction

    // Most gaps short, a few long enough to cover a whole search
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(40, 220);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                 what, result_count, want, got);
        mismatch_count++;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [31:0] value);
        t_stim_row row;
        row.kind  = kind;
        row.value = value;
        row.typed = 1'b0;
        row.want  = no_typed;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(input logic [31:0] value, input logic dbl,
                               input logic [1:0] psel, input logic [3:0] ssel,
                               input logic [spibd_pkg::RATE_W-1:0] rate,
                               input logic [31:0] err, input logic nf);
        t_stim_row row;
        row.kind                  = ROW_REQUEST;
        row.value                 = value;
        row.typed                 = 1'b1;
        row.want.double_rate      = dbl;
        row.want.prescaler_select = psel;
        row.want.scaler_select    = ssel;
        row.want.achieved_rate_hz = rate;
        row.want.rate_error_hz    = err;
        row.want.not_found        = nf;
        directed_rows.push_back(row);
    endtask

    // Called and returns at a falling edge; valid stays high after the transfer
    task automatic push_request(input logic [31:0] req, input bit typed,
                                input t_divider_result typed_want);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_requested_rate_hz <= req;
        do @(posedge i_clk); while (o_stall);
        divider_due.push_back(typed ? typed_want : best_divider(pclk_model, req));
        @(negedge i_clk);
    endtask

    // Clock register changes only once every pending result is out
    task automatic write_clock(input logic [spibd_pkg::CLK_W-1:0] value);
        i_valid <= 1'b0;
        while (divider_due.size() != 0) @(negedge i_clk);
        i_cfg_valid               <= 1'b1;
        i_cfg_peripheral_clock_hz <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pclk_model = value;
        clock_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, divider_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stall_gen
        int n;
        i_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            n = pick_idle();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_divider_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (o_not_found) begin
                not_found_count++;
            end
            if (o_rate_error_hz == '0) begin
                exact_count++;
            end
            if (divider_due.size() == 0) begin
                report_mismatch("result with none expected", 32'd0, o_rate_error_hz);
            end else begin
                want = divider_due.pop_front();
                if (o_double_rate !== want.double_rate)
                    report_mismatch("double_rate", 32'(want.double_rate),
                                    32'(o_double_rate));
                if (o_prescaler_select !== want.prescaler_select)
                    report_mismatch("prescaler_select", 32'(want.prescaler_select),
                                    32'(o_prescaler_select));
                if (o_scaler_select !== want.scaler_select)
                    report_mismatch("scaler_select", 32'(want.scaler_select),
                                    32'(o_scaler_select));
                if (o_achieved_rate_hz !== want.achieved_rate_hz)
                    report_mismatch("achieved_rate_hz", 32'(want.achieved_rate_hz),
                                    32'(o_achieved_rate_hz));
                if (o_rate_error_hz !== want.rate_error_hz)
                    report_mismatch("rate_error_hz", want.rate_error_hz,
                                    o_rate_error_hz);
                if (o_not_found !== want.not_found)
                    report_mismatch("not_found", 32'(want.not_found),
                                    32'(o_not_found));
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int        phase;
        int        k;

        i_rst_n                   = 1'b0;
        i_cfg_valid               = 1'b0;
        i_cfg_peripheral_clock_hz = '0;
        i_valid                   = 1'b0;
        i_requested_rate_hz       = '0;
        quiet                     = 1'b0;
        pclk_model                = spibd_pkg::PCLK_RESET;
        no_typed                  = best_divider(spibd_pkg::PCLK_RESET, 32'd0);

        // reset clock 84 MHz: base 42 MHz
        add_checked(32'd0, 1'b0, 2'd3, 4'd15, 28'd183, 32'd183, 1'b0);
        add_checked(32'hFFFF_FFFF, 1'b1, 2'd0, 4'd0, 28'd21000000, 32'd4273967295, 1'b0);
        add_checked(32'd21000000, 1'b1, 2'd0, 4'd0, 28'd21000000, 32'd0, 1'b0);
        // also reachable with the doubler on; the first setting must win
        add_checked(32'd10500000, 1'b0, 2'd0, 4'd0, 28'd10500000, 32'd0, 1'b0);
        add_row(ROW_REQUEST, 32'd1000000);
        add_row(ROW_REQUEST, 32'd183);
        add_row(ROW_REQUEST, 32'h8000_0000);
        add_row(ROW_REQUEST, 32'h5555_5555);
        // zero clock: every rate is zero
        add_row(ROW_CLOCK, 32'd0);
        add_checked(32'd0, 1'b0, 2'd0, 4'd0, 28'd0, 32'd0, 1'b0);
        add_checked(32'hFFFF_FFFF, 1'b0, 2'd0, 4'd0, 28'd0, 32'hFFFF_FFFF, 1'b1);
        add_checked(32'h1234_5678, 1'b0, 2'd0, 4'd0, 28'd0, 32'h1234_5678, 1'b0);
        // register full scale, beyond the nominal range
        add_row(ROW_CLOCK, 32'h1FFF_FFFF);
        add_checked(32'hFFFF_FFFF, 1'b1, 2'd0, 4'd0, 28'h7FF_FFFF, 32'hF800_0000, 1'b0);
        add_row(ROW_REQUEST, 32'd0);
        add_row(ROW_REQUEST, 32'h2AAA_AAAA);
        add_row(ROW_CLOCK, 32'd2);
        add_checked(32'hFFFF_FFFF, 1'b0, 2'd0, 4'd0, 28'd0, 32'hFFFF_FFFF, 1'b1);
        add_row(ROW_REQUEST, 32'd1);
        add_row(ROW_CLOCK, 32'd400000000);
        add_row(ROW_REQUEST, 32'd50000000);
        add_row(ROW_REQUEST, 32'd3000000);
        add_row(ROW_REQUEST, 32'd100000000);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_CLOCK) begin
                write_clock(row.value[spibd_pkg::CLK_W-1:0]);
            end else begin
                push_request(row.value, row.typed, row.want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            quiet = (phase % 4 == 3);
            write_clock(pick_clock());
            for (k = 0; k < PHASE_ITEMS; k++) begin
                push_request(gen_request(pclk_model), 1'b0, no_typed);
            end
        end

        i_valid <= 1'b0;
        while (divider_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d results checked across %0d clock settings", result_count,
                 clock_writes + 1);
        $display("%0d exact matches, %0d with no divider found", exact_count,
                 not_found_count);
        if (mismatch_count == 0 && divider_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/spibd_pkg.sv
rtl/spibd_cdiv.sv
rtl/spibd_dpath.sv
rtl/spibd_ctrl.sv
rtl/spi_baud_divider_search.sv
dv/tb_top.sv
